// ===== design/sacd_pkg.sv =====
// Package: shared types and constants for the SPI addressed command decoder.
`timescale 1ns / 1ps
`default_nettype none

package sacd_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 5;
  localparam int VOLT_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int SKIP_W     = 2;

  localparam logic [BYTE_W-1:0] PHASE_TICKS_RESET = 8'h78;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 1'b1;

  // Item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Header command field
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_IO    = 2'd1,
    CMD_VOLT0 = 2'd2,
    CMD_VOLT1 = 2'd3
  } cmd_t;

  // Byte decoder modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_SKIP = 3'd1,
    MODE_IO   = 3'd2,
    MODE_VHI  = 3'd3,
    MODE_VLO  = 3'd4
  } mode_t;

  // Pulse phases, also the drive code on the outputs
  typedef enum logic [1:0] {
    PH_OFF = 2'd0,
    PH_ONE = 2'd1,
    PH_TWO = 2'd2
  } phase_t;

  // Per-beat decoder result
  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              dac_valid;
    logic              dac_channel;
    logic [VOLT_W-1:0] dac_value;
  } dec_res_t;

  // Pulse start request from the decoder
  typedef struct packed {
    logic       start;
    logic [1:0] outputs;
  } pulse_req_t;

endpackage

`default_nettype wire

// ===== design/sacd_if.sv =====
// Interfaces: item, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface sacd_item_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [sacd_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, op, rx_byte, input ready);
  modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface sacd_result_if;
  logic                       valid;
  logic                       ready;
  logic                       tx_valid;
  logic [sacd_pkg::BYTE_W-1:0] tx_byte;
  logic                       dac_valid;
  logic                       dac_channel;
  logic [sacd_pkg::VOLT_W-1:0] dac_value;
  logic [1:0]                 drive_a;
  logic [1:0]                 drive_b;
  modport source (output valid, tx_valid, tx_byte, dac_valid, dac_channel, dac_value,
                  drive_a, drive_b, input ready);
  modport sink   (input valid, tx_valid, tx_byte, dac_valid, dac_channel, dac_value,
                  drive_a, drive_b, output ready);
endinterface

interface sacd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sacd_pkg::CFG_IDX_W-1:0] idx;
  logic [sacd_pkg::BYTE_W-1:0]    data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

// ===== design/sacd_decoder.sv =====
// Byte decoder: header/payload state machine and the two voltage registers.
`timescale 1ns / 1ps
`default_nettype none

module sacd_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [sacd_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic [sacd_pkg::ADDR_W-1:0]   own_address,
  output sacd_pkg::dec_res_t                 res,
  output sacd_pkg::pulse_req_t               preq
);

  sacd_pkg::mode_t                   mode, mode_next;
  logic [sacd_pkg::SKIP_W-1:0]       skip_left, skip_left_next;
  logic                              write_flag, write_flag_next;
  logic                              active_channel, active_channel_next;
  logic [sacd_pkg::BYTE_W-1:0]       high_byte, high_byte_next;
  logic [sacd_pkg::VOLT_W-1:0]       voltage [2];
  logic                              volt_we;
  logic [sacd_pkg::VOLT_W-1:0]       volt_rd;
  logic                              rd_sel;
  logic [sacd_pkg::VOLT_W-1:0]       new_volt;
  sacd_pkg::cmd_t                    cmd;

  assign cmd      = sacd_pkg::cmd_t'(rx_byte[6:5]);
  assign new_volt = {high_byte, rx_byte};

  // single read port: header picks by command, high-byte stage by latched channel
  assign rd_sel  = (mode == sacd_pkg::MODE_VHI) ? active_channel : rx_byte[5];
  assign volt_rd = voltage[rd_sel];

  // next state and beat result
  always_comb begin
    mode_next           = mode;
    skip_left_next      = skip_left;
    write_flag_next     = write_flag;
    active_channel_next = active_channel;
    high_byte_next      = high_byte;
    volt_we             = 1'b0;
    res                 = '0;
    preq                = '0;
    case (mode)
      sacd_pkg::MODE_SKIP: begin
        skip_left_next = skip_left - 1'b1;
        if (skip_left_next == '0) mode_next = sacd_pkg::MODE_IDLE;
      end
      sacd_pkg::MODE_IO: begin
        if (write_flag && (rx_byte[1:0] != 2'b00)) begin
          preq.start   = 1'b1;
          preq.outputs = rx_byte[1:0];
        end
        mode_next = sacd_pkg::MODE_IDLE;
      end
      sacd_pkg::MODE_VHI: begin
        high_byte_next = rx_byte;
        res.tx_valid   = 1'b1;
        res.tx_byte    = volt_rd[sacd_pkg::BYTE_W-1:0];
        mode_next      = sacd_pkg::MODE_VLO;
      end
      sacd_pkg::MODE_VLO: begin
        if (write_flag) begin
          volt_we         = 1'b1;
          res.dac_valid   = 1'b1;
          res.dac_channel = active_channel;
          res.dac_value   = new_volt;
        end
        mode_next = sacd_pkg::MODE_IDLE;
      end
      default: begin
        // header byte
        write_flag_next = rx_byte[7];
        if (rx_byte[sacd_pkg::ADDR_W-1:0] == own_address) begin
          if (cmd == sacd_pkg::CMD_IO) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = {{(sacd_pkg::BYTE_W-sacd_pkg::ADDR_W){1'b0}}, own_address};
            mode_next    = sacd_pkg::MODE_IO;
          end else if (cmd != sacd_pkg::CMD_NOP) begin
            active_channel_next = rx_byte[5];
            res.tx_valid        = 1'b1;
            res.tx_byte         = volt_rd[sacd_pkg::VOLT_W-1:sacd_pkg::BYTE_W];
            mode_next           = sacd_pkg::MODE_VHI;
          end
        end else if (cmd != sacd_pkg::CMD_NOP) begin
          skip_left_next = (cmd == sacd_pkg::CMD_IO) ? 2'd1 : 2'd2;
          mode_next      = sacd_pkg::MODE_SKIP;
        end
      end
    endcase
    if (!step) begin
      res  = '0;
      preq = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= sacd_pkg::MODE_IDLE;
      skip_left      <= '0;
      write_flag     <= 1'b0;
      active_channel <= 1'b0;
      high_byte      <= '0;
      voltage[0]     <= '0;
      voltage[1]     <= '0;
    end else if (step) begin
      mode           <= mode_next;
      skip_left      <= skip_left_next;
      write_flag     <= write_flag_next;
      active_channel <= active_channel_next;
      high_byte      <= high_byte_next;
      if (volt_we) voltage[active_channel] <= new_volt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sacd_pulse.sv =====
// Biphasic pulse driver: phase sequencer and tick counter.
`timescale 1ns / 1ps
`default_nettype none

module sacd_pulse (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        tick,
  input  wire sacd_pkg::pulse_req_t        preq,
  input  wire logic [sacd_pkg::BYTE_W-1:0] phase_ticks,
  output logic [1:0]                       drive_a,
  output logic [1:0]                       drive_b
);

  sacd_pkg::phase_t             phase, phase_next;
  logic [sacd_pkg::BYTE_W-1:0]  count, count_next, count_dec;
  logic [1:0]                   outputs, outputs_next;
  logic [sacd_pkg::BYTE_W-1:0]  load;

  // zero ticks behaves as one
  assign load      = (phase_ticks == '0) ? {{(sacd_pkg::BYTE_W-1){1'b0}}, 1'b1} : phase_ticks;
  assign count_dec = count - 1'b1;

  // phase sequencing
  always_comb begin
    phase_next   = phase;
    count_next   = count;
    outputs_next = outputs;
    if (preq.start) begin
      phase_next   = sacd_pkg::PH_ONE;
      count_next   = load;
      outputs_next = preq.outputs;
    end else if (tick && (phase != sacd_pkg::PH_OFF)) begin
      count_next = count_dec;
      if (count_dec == '0) begin
        if (phase == sacd_pkg::PH_ONE) begin
          phase_next = sacd_pkg::PH_TWO;
          count_next = load;
        end else begin
          phase_next = sacd_pkg::PH_OFF;
        end
      end
    end
  end

  // drive as it stands after this beat
  assign drive_a = outputs_next[0] ? phase_next : sacd_pkg::PH_OFF;
  assign drive_b = outputs_next[1] ? phase_next : sacd_pkg::PH_OFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= sacd_pkg::PH_OFF;
      count   <= '0;
      outputs <= '0;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      outputs <= outputs_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/spi_addressed_command_decoder.sv =====
// Top level: input register, decoder and pulse driver, result register.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is either a received SPI byte or one time tick; every beat
// gives exactly one result beat carrying the reply byte to load (if any), a
// DAC write request (if any) and the A/B pulse drive as it stands after the
// beat. A beat is captured in an input register, decoded combinationally and
// lands in a result register, so the block takes one beat per clock while it
// is not stalled; it stalls only when the result register is full and
// the sink is not ready. Configuration writes (own address, ticks per phase)
// are registered and are meant to be made while the block is idle.

module spi_addressed_command_decoder (
  input  wire logic     clk,
  input  wire logic     rst,
  sacd_item_if.sink     item,
  sacd_result_if.source result,
  sacd_cfg_if.sink      cfg
);

  logic                          s1_valid;
  logic                          s1_op;
  logic [sacd_pkg::BYTE_W-1:0]   s1_byte;
  logic                          advance;
  logic [sacd_pkg::ADDR_W-1:0]   own_address;
  logic [sacd_pkg::BYTE_W-1:0]   phase_ticks;
  sacd_pkg::dec_res_t            dec_res;
  sacd_pkg::pulse_req_t          preq;
  logic [1:0]                    drive_a, drive_b;

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
      phase_ticks <= sacd_pkg::PHASE_TICKS_RESET;
    end else if (cfg.valid) begin
      case (cfg.idx)
        sacd_pkg::REG_OWN_ADDRESS: own_address <= cfg.data[sacd_pkg::ADDR_W-1:0];
        sacd_pkg::REG_PHASE_TICKS: phase_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op   <= item.op;
      s1_byte <= item.rx_byte;
    end
  end

  sacd_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .step        (advance && (s1_op == sacd_pkg::OP_BYTE)),
    .rx_byte     (s1_byte),
    .own_address (own_address),
    .res         (dec_res),
    .preq        (preq)
  );

  sacd_pulse u_pulse (
    .clk         (clk),
    .rst         (rst),
    .tick        (advance && (s1_op == sacd_pkg::OP_TICK)),
    .preq        (preq),
    .phase_ticks (phase_ticks),
    .drive_a     (drive_a),
    .drive_b     (drive_b)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.tx_valid    <= dec_res.tx_valid;
      result.tx_byte     <= dec_res.tx_byte;
      result.dac_valid   <= dec_res.dac_valid;
      result.dac_channel <= dec_res.dac_channel;
      result.dac_value   <= dec_res.dac_value;
      result.drive_a     <= drive_a;
      result.drive_b     <= drive_b;
    end
  end

endmodule

`default_nettype wire

// ===== design/sacd_checker.sv =====
// Checker: port-level properties of the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sacd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        tx_valid,
  input wire logic [sacd_pkg::BYTE_W-1:0] tx_byte,
  input wire logic                        dac_valid,
  input wire logic [1:0]                  drive_a,
  input wire logic [1:0]                  drive_b
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(drive_a))
    else $error("result beat changed while stalled");

  // a reply byte and a DAC write never come from the same beat
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_valid && dac_valid))
    else $error("reply and DAC write in one beat");

  // no reply means a zero reply byte
  a_txzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == '0)
    else $error("reply byte set without reply");

  // both outputs run one shared phase
  a_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && (drive_a != 2'd0) && (drive_b != 2'd0) |-> drive_a == drive_b)
    else $error("outputs in different phases");

endmodule

bind spi_addressed_command_decoder sacd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .tx_valid  (result.tx_valid),
  .tx_byte   (result.tx_byte),
  .dac_valid (result.dac_valid),
  .drive_a   (result.drive_a),
  .drive_b   (result.drive_b)
);

`default_nettype wire
